@@ sv/omq16_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Q16.16 octonion multiplier.
// Holds the lane width, the quaternion type and the transfer structs; depends on nothing.
package omq16_pkg;

    localparam int LANE_W = 32;
    localparam int FRAC_W = 16;

    typedef struct packed {
        logic [LANE_W-1:0] z;
        logic [LANE_W-1:0] y;
        logic [LANE_W-1:0] x;
        logic [LANE_W-1:0] w;
    } t_quat;

    typedef struct packed {
        logic [2*LANE_W-1:0] a_e01;
        logic [2*LANE_W-1:0] a_e23;
        logic [2*LANE_W-1:0] a_e45;
        logic [2*LANE_W-1:0] a_e67;
        logic [2*LANE_W-1:0] b_e01;
        logic [2*LANE_W-1:0] b_e23;
        logic [2*LANE_W-1:0] b_e45;
        logic [2*LANE_W-1:0] b_e67;
    } t_oct_in;

    typedef struct packed {
        logic [2*LANE_W-1:0] p_e01;
        logic [2*LANE_W-1:0] p_e23;
        logic [2*LANE_W-1:0] p_e45;
        logic [2*LANE_W-1:0] p_e67;
    } t_oct_out;

endpackage

@@ sv/octonion_multiply_q16_unit.sv @@
`timescale 1ns / 1ps
// Top level of the Q16.16 octonion multiplier (Cayley-Dickson product of two octonions).
// Depends on omq16_pkg and omq16_hamilton.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------
//  operands  | i_start, o_busy      | i_operands (t_oct_in)
//  result    | o_strobe             | o_result   (t_oct_out)
//
// A transfer in is taken on every edge with i_start high; o_busy is never raised.
// The result passes the operand, product, sum and result registers on its way to the ports.
// One result can leave per cycle.
// Stages: operand register, 32x32 multiplier array, quaternion sums, final add and output.
// Reset clears only the stage valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline always advances.
module octonion_multiply_q16_unit
    import omq16_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_oct_in  i_operands,
    output logic     o_strobe,
    output t_oct_out o_result
);

    logic     r_v0;
    logic     r_v1;
    logic     r_v2;
    logic     r_v3;
    t_quat    r_p;
    t_quat    r_q;
    t_quat    r_r;
    t_quat    r_s;
    t_quat    r_rc;
    t_quat    r_sc;
    t_quat    pr;
    t_quat    sq;
    t_quat    sp;
    t_quat    qr;
    t_oct_out n_result;
    t_oct_out r_result;
    logic     accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= {i_operands.a_e23, i_operands.a_e01};
        r_q  <= {i_operands.a_e67, i_operands.a_e45};
        r_r  <= {i_operands.b_e23, i_operands.b_e01};
        r_s  <= {i_operands.b_e67, i_operands.b_e45};
        r_rc.w <= i_operands.b_e01[LANE_W-1:0];
        r_rc.x <= '0 - i_operands.b_e01[2*LANE_W-1:LANE_W];
        r_rc.y <= '0 - i_operands.b_e23[LANE_W-1:0];
        r_rc.z <= '0 - i_operands.b_e23[2*LANE_W-1:LANE_W];
        r_sc.w <= i_operands.b_e45[LANE_W-1:0];
        r_sc.x <= '0 - i_operands.b_e45[2*LANE_W-1:LANE_W];
        r_sc.y <= '0 - i_operands.b_e67[LANE_W-1:0];
        r_sc.z <= '0 - i_operands.b_e67[2*LANE_W-1:LANE_W];
    end

    omq16_hamilton u_pr (.i_clk(i_clk), .i_a(r_p),  .i_b(r_r),  .o_prod(pr));
    omq16_hamilton u_sq (.i_clk(i_clk), .i_a(r_sc), .i_b(r_q),  .o_prod(sq));
    omq16_hamilton u_sp (.i_clk(i_clk), .i_a(r_s),  .i_b(r_p),  .o_prod(sp));
    omq16_hamilton u_qr (.i_clk(i_clk), .i_a(r_q),  .i_b(r_rc), .o_prod(qr));

    always_comb begin
        n_result.p_e01 = {pr.x - sq.x, pr.w - sq.w};
        n_result.p_e23 = {pr.z - sq.z, pr.y - sq.y};
        n_result.p_e45 = {sp.x + qr.x, sp.w + qr.w};
        n_result.p_e67 = {sp.z + qr.z, sp.y + qr.y};
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_v3;
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_strobe)
        else $error("accepted transfer did not produce a result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##4 !o_strobe)
        else $error("result strobe without a matching transfer");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a pipeline that cannot stall");

    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_operands.b_e01, 4) == 64'h0000_0000_0001_0000
            && $past(i_operands.b_e23, 4) == 64'h0
            && $past(i_operands.b_e45, 4) == 64'h0
            && $past(i_operands.b_e67, 4) == 64'h0)
        |-> (o_result.p_e01 == $past(i_operands.a_e01, 4)
            && o_result.p_e23 == $past(i_operands.a_e23, 4)
            && o_result.p_e45 == $past(i_operands.a_e45, 4)
            && o_result.p_e67 == $past(i_operands.a_e67, 4)))
        else $error("product by the unit octonion differs from the first operand");

endmodule

@@ sv/omq16_hamilton.sv @@
`timescale 1ns / 1ps
// Two-stage Hamilton quaternion product in Q16.16: sixteen registered products, then sums.
// Depends on omq16_pkg.
module omq16_hamilton
    import omq16_pkg::*;
(
    input  logic  i_clk,
    input  t_quat i_a,
    input  t_quat i_b,
    output t_quat o_prod
);

    logic [LANE_W-1:0] n_mul [16];
    logic [LANE_W-1:0] r_mul [16];
    logic [LANE_W-1:0] a_l [4];
    logic [LANE_W-1:0] b_l [4];
    t_quat n_sum;
    t_quat r_sum;

    assign a_l[0] = i_a.w;
    assign a_l[1] = i_a.x;
    assign a_l[2] = i_a.y;
    assign a_l[3] = i_a.z;
    assign b_l[0] = i_b.w;
    assign b_l[1] = i_b.x;
    assign b_l[2] = i_b.y;
    assign b_l[3] = i_b.z;

    // Product index is 4*i + j for a lane i times b lane j.
    for (genvar i = 0; i < 4; i++) begin : g_row
        for (genvar j = 0; j < 4; j++) begin : g_col
            logic signed [2*LANE_W-1:0] full;
            assign full = $signed(a_l[i]) * $signed(b_l[j]);
            assign n_mul[4*i+j] = full[FRAC_W +: LANE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= n_mul;
    end

    always_comb begin
        n_sum.w = r_mul[0]  - r_mul[5]  - r_mul[10] - r_mul[15];
        n_sum.x = r_mul[1]  + r_mul[4]  + r_mul[11] - r_mul[14];
        n_sum.y = r_mul[2]  - r_mul[7]  + r_mul[8]  + r_mul[13];
        n_sum.z = r_mul[3]  + r_mul[6]  - r_mul[9]  + r_mul[12];
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_prod = r_sum;

endmodule
